### rtl/text_terminal_cursor_scroll_macros.svh
// Assertion macros for the character-cell terminal.
// Included by the top level; ASSERT_OFF turns every check into nothing.
`ifndef TEXT_TERMINAL_CURSOR_SCROLL_MACROS_SVH
`define TEXT_TERMINAL_CURSOR_SCROLL_MACROS_SVH
`ifndef ASSERT_OFF
`define TTCS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ttcs check failed");
`define TTCS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ttcs check failed");
`else
`define TTCS_ASSERT(label, clk, rst_n, prop)
`define TTCS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### rtl/ttcs_pkg.sv
// Shared types and constants of the character-cell terminal.
// No dependencies; used by the front, back and top level.
`default_nettype none
package ttcs_pkg;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ROW_IN_W = 5;
  localparam int COL_IN_W = 7;
  localparam int POS_W = 11;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int REG_IDX_W = 2;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_FIRST = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h00;

  localparam logic [ATTR_W-1:0] TEXT_ATTR_RESET  = 8'd3;
  localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET = 8'd11;

  localparam logic [REG_IDX_W-1:0] REG_TEXT_ATTR  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BLANK_ATTR = 2'd1;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_PRINT,
    CMD_BS,
    CMD_TAB,
    CMD_LF,
    CMD_CR,
    CMD_READ,
    CMD_READ_NONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [CHAR_W-1:0]     ch;
    logic [ROW_IN_W-1:0]   row;
    logic [COL_IN_W-1:0]   col;
  } ttcs_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic              scrolled;
  } ttcs_res_t;

endpackage
`default_nettype wire

### rtl/ttcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ttcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/ttcs_front.sv
// Front end: accepts items, decodes them into commands, and queues them.
// Depends on ttcs_pkg.
`default_nettype none
module ttcs_front
  import ttcs_pkg::*;
#(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire logic                in_action,
  input  wire logic [CHAR_W-1:0]   in_char_code,
  input  wire logic [ROW_IN_W-1:0] in_read_row,
  input  wire logic [COL_IN_W-1:0] in_read_col,
  input  wire logic                hold,
  output logic                     in_full,
  output logic                     cmd_valid,
  output ttcs_cmd_t                cmd,
  input  wire logic                cmd_pop
);

  localparam int QDEPTH = 2;

  ttcs_cmd_t   q_r [QDEPTH];
  logic        wp_r, wp_nxt;
  logic        rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  ttcs_cmd_t   dec;
  logic        push_fire;
  logic        pop_fire;

  always_comb begin
    dec.ch  = in_char_code;
    dec.row = in_read_row;
    dec.col = in_read_col;
    if (in_action) begin
      if (int'(in_read_row) < ROWS && int'(in_read_col) < COLS) begin
        dec.kind = CMD_READ;
      end else begin
        dec.kind = CMD_READ_NONE;
      end
    end else if (in_char_code >= CH_FIRST && in_char_code <= CH_LAST) begin
      dec.kind = CMD_PRINT;
    end else begin
      case (in_char_code)
        CH_BS:   dec.kind = CMD_BS;
        CH_TAB:  dec.kind = CMD_TAB;
        CH_LF:   dec.kind = CMD_LF;
        CH_CR:   dec.kind = CMD_CR;
        default: dec.kind = CMD_NOP;
      endcase
    end
  end

  assign in_full   = (cnt_r == 2'(QDEPTH)) || hold;
  assign push_fire = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop_fire  = cmd_pop && cmd_valid;
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push_fire ? ~wp_r : wp_r;
    rp_nxt  = pop_fire ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push_fire && !pop_fire) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop_fire && !push_fire) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule
`default_nettype wire

### rtl/ttcs_back.sv
// Back end: cursor, screen store, scroll and clear sequencer, result register.
// Depends on ttcs_pkg and ttcs_ram.
`default_nettype none
module ttcs_back
  import ttcs_pkg::*;
#(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [ATTR_W-1:0] text_attr,
  input  wire logic [ATTR_W-1:0] blank_attr,
  input  wire logic              cmd_valid,
  input  ttcs_cmd_t              cmd,
  output logic                   cmd_pop,
  output logic                   clearing,
  input  wire logic              res_pop,
  output logic                   res_valid,
  output ttcs_res_t              res
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW = $clog2(CELLS);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int LAST_COPY = (ROWS - 1) * COLS;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_COPY  = 5'b01000,
    ST_FILL  = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   pend_addr_r, pend_addr_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic            out_valid_r, out_valid_nxt;
  ttcs_res_t       res_r, res_nxt;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [CELL_W-1:0] wdata;
  logic [AW-1:0]   raddr;
  logic [CELL_W-1:0] rdata;

  logic            slot_free;
  logic            issue;
  logic [CW:0]     col_w;
  logic [RW:0]     row_w;
  logic [CW:0]     col_n;
  logic [RW:0]     row_n;
  logic            scroll_need;
  logic [RW-1:0]   row_fin;
  logic [CW-1:0]   col_fin;
  logic [AW-1:0]   rd_lin;

  function automatic logic [AW-1:0] lin(input logic [RW-1:0] r, input logic [CW-1:0] c);
    lin = AW'(AW'(r) * AW'(COLS)) + AW'(c);
  endfunction

  ttcs_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign slot_free = !out_valid_r || res_pop;
  assign issue     = (state_r == ST_IDLE) && cmd_valid && slot_free;
  assign cmd_pop   = issue;
  assign clearing  = (state_r == ST_CLEAR);
  assign res_valid = out_valid_r;
  assign res       = res_r;
  assign rd_lin    = AW'(AW'(cmd.row) * AW'(COLS)) + AW'(cmd.col);

  // cursor move for put commands
  always_comb begin
    col_w = {1'b0, col_r};
    row_w = {1'b0, row_r};
    col_n = col_w;
    row_n = row_w;
    case (cmd.kind)
      CMD_PRINT: col_n = col_w + (CW+1)'(1);
      CMD_BS:    col_n = (col_r != '0) ? col_w - (CW+1)'(1) : col_w;
      CMD_TAB:   col_n = (col_w + (CW+1)'(8)) & ~(CW+1)'(7);
      CMD_LF: begin
        col_n = '0;
        row_n = row_w + (RW+1)'(1);
      end
      CMD_CR:    col_n = '0;
      default:   col_n = col_w;
    endcase
    if (col_n >= (CW+1)'(COLS)) begin
      col_n = '0;
      row_n = row_n + (RW+1)'(1);
    end
    scroll_need = (row_n >= (RW+1)'(ROWS));
    row_fin     = scroll_need ? RW'(ROWS - 1) : row_n[RW-1:0];
    col_fin     = col_n[CW-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    out_valid_nxt = out_valid_r && !res_pop;
    res_nxt       = res_r;
    we            = 1'b0;
    waddr         = cnt_r;
    wdata         = {CH_BLANK, blank_attr};
    raddr         = rd_lin;

    case (state_r)
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = {CH_BLANK, BLANK_ATTR_RESET};
        if (cnt_r == AW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (issue) begin
          case (cmd.kind)
            CMD_READ: state_nxt = ST_READ;
            CMD_READ_NONE: begin
              res_nxt       = '{cursor_pos: POS_W'(lin(row_r, col_r)),
                                cell_char: '0, cell_attr: '0, scrolled: 1'b0};
              out_valid_nxt = 1'b1;
            end
            default: begin
              if (cmd.kind == CMD_PRINT) begin
                we    = 1'b1;
                waddr = lin(row_r, col_r);
                wdata = {cmd.ch, text_attr};
              end
              row_nxt = row_fin;
              col_nxt = col_fin;
              if (scroll_need) begin
                cnt_nxt   = '0;
                pend_nxt  = 1'b0;
                state_nxt = ST_COPY;
              end else begin
                res_nxt       = '{cursor_pos: POS_W'(lin(row_fin, col_fin)),
                                  cell_char: '0, cell_attr: '0, scrolled: 1'b0};
                out_valid_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        res_nxt       = '{cursor_pos: POS_W'(lin(row_r, col_r)),
                          cell_char: rdata[CELL_W-1:ATTR_W],
                          cell_attr: rdata[ATTR_W-1:0], scrolled: 1'b0};
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_COPY: begin
        // read one row ahead, write the previous read back one row up
        raddr = cnt_r + AW'(COLS);
        if (pend_r) begin
          we    = 1'b1;
          waddr = pend_addr_r;
          wdata = rdata;
        end
        if (cnt_r == AW'(LAST_COPY)) begin
          pend_nxt  = 1'b0;
          state_nxt = ST_FILL;
        end else begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = cnt_r;
          cnt_nxt       = cnt_r + AW'(1);
        end
      end
      ST_FILL: begin
        we = 1'b1;
        if (cnt_r == AW'(CELLS - 1)) begin
          res_nxt       = '{cursor_pos: POS_W'(lin(row_r, col_r)),
                            cell_char: '0, cell_attr: '0, scrolled: 1'b1};
          out_valid_nxt = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    res_r       <= res_nxt;
  end

endmodule
`default_nettype wire

### rtl/text_terminal_cursor_scroll.sv
// Character-cell terminal top level: config registers, front end, back end.
// Depends on ttcs_pkg, ttcs_front, ttcs_back and the assertion macro header.
//
// Usage:
//   Input queue: drive in_* fields and raise in_push; the item is taken on an
//   edge where in_full is low. action 0 puts a byte, action 1 reads a cell.
//   Result queue: while out_empty is low the oldest result is on out_*; it
//   is taken on an edge with out_pop high. Exactly one result per item.
//   Config: cfg_index 0 = text attribute, 1 = blank attribute; a write is
//   taken when cfg_valid and cfg_ready are high (cfg_ready is always high).
//   A put result passes the command queue and result register; a read also
//   passes the RAM read register and ST_READ. Throughput: one put per cycle
//   while out_pop is high and nothing scrolls; a read holds the back end in
//   ST_READ before the next item issues. The back end issues in the same
//   cycle its result is popped. A scrolling put walks the screen RAM (one
//   read and one write port) in ST_COPY, blanks the last row in ST_FILL and
//   then gives its result; queued input waits. Reset: cursor 0, attributes
//   3/11, then a clearing pass over all ROWS*COLS cells blanks the store
//   while in_full stays high. A stalled result holds; the two-entry command
//   queue takes two more items, then in_full rises till the result is popped.
`default_nettype none
`include "text_terminal_cursor_scroll_macros.svh"
module text_terminal_cursor_scroll
  import ttcs_pkg::*;
#(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic                 in_action,
  input  wire logic [CHAR_W-1:0]    in_char_code,
  input  wire logic [ROW_IN_W-1:0]  in_read_row,
  input  wire logic [COL_IN_W-1:0]  in_read_col,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic [POS_W-1:0]          out_cursor_pos,
  output logic [CHAR_W-1:0]         out_cell_char,
  output logic [ATTR_W-1:0]         out_cell_attr,
  output logic                      out_scrolled,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [ATTR_W-1:0]    cfg_data
);

  logic [ATTR_W-1:0] text_attr_r, text_attr_nxt;
  logic [ATTR_W-1:0] blank_attr_r, blank_attr_nxt;
  logic              clearing;
  logic              cmd_valid;
  logic              cmd_pop;
  ttcs_cmd_t         cmd;
  logic              res_valid;
  ttcs_res_t         res;

  assign cfg_ready = 1'b1;

  always_comb begin
    text_attr_nxt  = text_attr_r;
    blank_attr_nxt = blank_attr_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TEXT_ATTR:  text_attr_nxt  = cfg_data;
        REG_BLANK_ATTR: blank_attr_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r  <= TEXT_ATTR_RESET;
      blank_attr_r <= BLANK_ATTR_RESET;
    end else begin
      text_attr_r  <= text_attr_nxt;
      blank_attr_r <= blank_attr_nxt;
    end
  end

  ttcs_front #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_action   (in_action),
    .in_char_code(in_char_code),
    .in_read_row (in_read_row),
    .in_read_col (in_read_col),
    .hold        (clearing),
    .in_full     (in_full),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  ttcs_back #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .text_attr (text_attr_r),
    .blank_attr(blank_attr_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .res_pop   (out_pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_empty      = !res_valid;
  assign out_cursor_pos = res.cursor_pos;
  assign out_cell_char  = res.cell_char;
  assign out_cell_attr  = res.cell_attr;
  assign out_scrolled   = res.scrolled;

  `TTCS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> out_empty && in_full)
  `TTCS_ASSERT(a_cursor_range, clk, rst_n, !out_empty |-> int'(out_cursor_pos) < ROWS * COLS)
  `TTCS_ASSERT(a_scroll_no_cell, clk, rst_n,
               !out_empty && out_scrolled |-> out_cell_char == '0 && out_cell_attr == '0)

endmodule
`default_nettype wire
